// File: src/bloom_filter_double_hash_defines.svh
// assertion macros for the bloom filter with double hashing
// used by the top level only, no other dependencies
`ifndef BLOOM_FILTER_DOUBLE_HASH_DEFINES_SVH
`define BLOOM_FILTER_DOUBLE_HASH_DEFINES_SVH

`ifndef SYNTHESIS
`define BFDH_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("bfdh: same-cycle check failed");
`define BFDH_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("bfdh: next-cycle check failed");
`else
`define BFDH_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define BFDH_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

// File: src/bfdh_pkg.sv
// constants and hash helper functions for the bloom filter with double hashing
// no dependencies
`default_nettype none

package bfdh_pkg;

  localparam logic [63:0] SEED_PRI   = 64'hcbf29ce484222325;
  localparam logic [63:0] SEED_SEC   = 64'h84222325cbf29ce4;
  localparam logic [63:0] GOLDEN_ADD = 64'h000000009e3779b9;
  localparam logic [63:0] MIX_C1     = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2     = 64'hc4ceb9fe1a85ec53;

  localparam logic [4:0] HASH_COUNT_RST = 5'd12;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // multiply by the fnv prime 2^40 + 0x1b3, low 64 bits
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  function automatic logic [63:0] xshift33(input logic [63:0] v);
    return v ^ (v >> 33);
  endfunction

  function automatic logic [63:0] primary_step(input logic [63:0] h, input logic [7:0] b);
    return fnv_mul(h ^ {56'd0, b});
  endfunction

  function automatic logic [63:0] secondary_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] t;
    t = h ^ ({56'd0, b} + GOLDEN_ADD);
    return fnv_mul({t[50:0], t[63:51]});
  endfunction

endpackage

`default_nettype wire

// File: src/bloom_filter_double_hash.sv
// Bloom filter with double hashing over a 2^FILTER_INDEX_BITS bit store. Keys come in one
// byte per word; after a non-final byte the front end is ready for the next. On the final
// byte it runs the murmur finalizer on both hashes through one shared 32x32 multiplier,
// four 64-bit multiplies in all, and takes no new bytes until the job has been pushed.
// The back end then probes hash_count bits through the single bit-store port, one a cycle;
// a two-entry job queue lets it run while the front end hashes the next key. After reset
// a clearing pass zeroes the bit store, and no key word is taken until it ends; hash_count
// may be written meanwhile.
// depends on bfdh_pkg, bfdh_front, bfdh_job_fifo, bfdh_back and the assertion macro header
`default_nettype none
`include "bloom_filter_double_hash_defines.svh"

module bloom_filter_double_hash #(
  parameter int FILTER_INDEX_BITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [4:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_key_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_done_command,
  output logic             out_maybe_present,
  output logic [31:0]      out_entries_added
);

  localparam int JOB_W = 1 + 2 * FILTER_INDEX_BITS;

  logic                         clearing;
  logic                         push_valid, push_ready, pop_valid, pop_ready;
  logic                         push_cmd, pop_cmd;
  logic [FILTER_INDEX_BITS-1:0] push_pos, push_step, pop_pos, pop_step;
  logic [JOB_W-1:0]             push_data, pop_data;

  bfdh_front #(
    .IDX_W(FILTER_INDEX_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .hold         (clearing),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_key_byte  (in_key_byte),
    .in_last_byte (in_last_byte),
    .job_valid    (push_valid),
    .job_ready    (push_ready),
    .job_cmd      (push_cmd),
    .job_pos      (push_pos),
    .job_step     (push_step)
  );

  assign push_data = {push_cmd, push_pos, push_step};

  bfdh_job_fifo #(
    .W(JOB_W)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_cmd  = pop_data[JOB_W-1];
  assign pop_pos  = pop_data[2*FILTER_INDEX_BITS-1:FILTER_INDEX_BITS];
  assign pop_step = pop_data[FILTER_INDEX_BITS-1:0];

  bfdh_back #(
    .IDX_W(FILTER_INDEX_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .job_valid         (pop_valid),
    .job_ready         (pop_ready),
    .job_cmd           (pop_cmd),
    .job_pos           (pop_pos),
    .job_step          (pop_step),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_done_command  (out_done_command),
    .out_maybe_present (out_maybe_present),
    .out_entries_added (out_entries_added),
    .clearing          (clearing)
  );

  `BFDH_ASSERT_IMP(a_clear_blocks_input, clk, rst_n, clearing, !in_ready && !pop_ready)
  `BFDH_ASSERT_NXT(a_last_byte_stalls, clk, rst_n,
                   in_valid && in_ready && in_last_byte, !in_ready)
  `BFDH_ASSERT_IMP(a_insert_not_present, clk, rst_n,
                   out_valid && (out_done_command == bfdh_pkg::CMD_INSERT), !out_maybe_present)

endmodule

`default_nettype wire

// File: src/bfdh_front.sv
// front end: takes key words, runs both byte hashes and the finalizer
// depends on bfdh_pkg; the finalizer shares one 32x32 multiplier
`default_nettype none

module bfdh_front #(
  parameter int IDX_W = 20
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             hold,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_command,
  input  wire logic [7:0]       in_key_byte,
  input  wire logic             in_last_byte,
  output logic                  job_valid,
  input  wire logic             job_ready,
  output logic                  job_cmd,
  output logic [IDX_W-1:0]      job_pos,
  output logic [IDX_W-1:0]      job_step
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MIX  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]       state_r;
  logic [63:0]      h1_r, h2_r;
  logic [63:0]      opnd_r, m_r;
  logic [1:0]       ph_r;
  logic             cst_r, sel_r, cmd_r;
  logic [IDX_W-1:0] pos_r, step_r;

  logic [63:0] h1_nxt, h2_nxt;
  logic [63:0] kconst, prod, mix_v;
  logic [31:0] mul_a, mul_b, m_hi_nxt;
  logic        in_fire;

  assign h1_nxt  = bfdh_pkg::primary_step(h1_r, in_key_byte);
  assign h2_nxt  = bfdh_pkg::secondary_step(h2_r, in_key_byte);
  assign in_ready = (state_r == ST_IDLE) && !hold;
  assign in_fire  = in_valid && in_ready;

  // low 64 bits of a*k from three partial products
  assign kconst   = cst_r ? bfdh_pkg::MIX_C2 : bfdh_pkg::MIX_C1;
  assign mul_a    = (ph_r == 2'd2) ? opnd_r[63:32] : opnd_r[31:0];
  assign mul_b    = (ph_r == 2'd1) ? kconst[63:32] : kconst[31:0];
  assign prod     = {32'd0, mul_a} * {32'd0, mul_b};
  assign m_hi_nxt = m_r[63:32] + prod[31:0];
  assign mix_v    = bfdh_pkg::xshift33(m_r);

  assign job_valid = (state_r == ST_PUSH);
  assign job_cmd   = cmd_r;
  assign job_pos   = pos_r;
  assign job_step  = step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      h1_r    <= bfdh_pkg::SEED_PRI;
      h2_r    <= bfdh_pkg::SEED_SEC;
      ph_r    <= 2'd0;
      cst_r   <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            h1_r  <= h1_nxt;
            h2_r  <= h2_nxt;
            cmd_r <= in_command;
            if (in_last_byte) begin
              opnd_r  <= bfdh_pkg::xshift33(h1_nxt);
              ph_r    <= 2'd0;
              cst_r   <= 1'b0;
              sel_r   <= 1'b0;
              state_r <= ST_MIX;
            end
          end
        end
        ST_MIX: begin
          case (ph_r)
            2'd0: begin
              m_r  <= prod;
              ph_r <= 2'd1;
            end
            2'd1: begin
              m_r[63:32] <= m_hi_nxt;
              ph_r       <= 2'd2;
            end
            2'd2: begin
              m_r[63:32] <= m_hi_nxt;
              ph_r       <= 2'd3;
            end
            default: begin
              ph_r <= 2'd0;
              if (!cst_r) begin
                opnd_r <= mix_v;
                cst_r  <= 1'b1;
              end else begin
                cst_r <= 1'b0;
                if (!sel_r) begin
                  pos_r  <= mix_v[IDX_W-1:0];
                  opnd_r <= bfdh_pkg::xshift33(h2_r);
                  sel_r  <= 1'b1;
                end else begin
                  step_r  <= mix_v[IDX_W-1:0];
                  sel_r   <= 1'b0;
                  state_r <= ST_PUSH;
                end
              end
            end
          endcase
        end
        ST_PUSH: begin
          if (job_ready) begin
            h1_r    <= bfdh_pkg::SEED_PRI;
            h2_r    <= bfdh_pkg::SEED_SEC;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/bfdh_job_fifo.sv
// two-entry queue of probe jobs between front and back end
// no dependencies
`default_nettype none

module bfdh_job_fifo #(
  parameter int W = 41
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire logic [W-1:0] push_data,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output logic [W-1:0]      pop_data
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r;
  logic         push_fire, pop_fire;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop_fire) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push_fire && !pop_fire) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop_fire && !push_fire) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/bfdh_back.sv
// back end: bit store with clearing pass, probe sequencer, entry counter, result register
// depends on bfdh_pkg
`default_nettype none

module bfdh_back #(
  parameter int IDX_W = 20
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [4:0]       cfg_wr_data,
  input  wire logic             job_valid,
  output logic                  job_ready,
  input  wire logic             job_cmd,
  input  wire logic [IDX_W-1:0] job_pos,
  input  wire logic [IDX_W-1:0] job_step,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_done_command,
  output logic                  out_maybe_present,
  output logic [31:0]           out_entries_added,
  output logic                  clearing
);

  localparam int DEPTH = 1 << IDX_W;

  localparam logic [2:0] B_CLEAR = 3'd0;
  localparam logic [2:0] B_IDLE  = 3'd1;
  localparam logic [2:0] B_PROBE = 3'd2;
  localparam logic [2:0] B_DRAIN = 3'd3;
  localparam logic [2:0] B_DONE  = 3'd4;

  logic bit_mem [DEPTH];

  logic [2:0]       state_r;
  logic [4:0]       hc_r, cnt_r;
  logic [IDX_W-1:0] clr_r, pos_r, step_r;
  logic             cmd_r, allset_r, rd_vld_r, rd_bit_r;
  logic [31:0]      total_r, total_nxt;
  logic             out_valid_r, out_cmd_r, out_present_r;
  logic [31:0]      out_total_r;

  logic             mem_we, mem_re, mem_wbit;
  logic [IDX_W-1:0] mem_waddr;
  logic             out_free;

  assign clearing  = (state_r == B_CLEAR);
  assign job_ready = (state_r == B_IDLE);
  assign mem_we    = clearing || ((state_r == B_PROBE) && (cmd_r == bfdh_pkg::CMD_INSERT));
  assign mem_re    = (state_r == B_PROBE) && (cmd_r == bfdh_pkg::CMD_QUERY);
  assign mem_waddr = clearing ? clr_r : pos_r;
  assign mem_wbit  = !clearing;
  assign out_free  = !out_valid_r || out_ready;
  assign total_nxt = ((cmd_r == bfdh_pkg::CMD_INSERT) && (total_r != 32'hffffffff))
                     ? total_r + 32'd1 : total_r;

  assign out_valid         = out_valid_r;
  assign out_done_command  = out_cmd_r;
  assign out_maybe_present = out_present_r;
  assign out_entries_added = out_total_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bit_mem[mem_waddr] <= mem_wbit;
    end
    if (mem_re) begin
      rd_bit_r <= bit_mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r <= bfdh_pkg::HASH_COUNT_RST;
    end else if (cfg_wr_en) begin
      hc_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      rd_vld_r    <= 1'b0;
      total_r     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= mem_re;
      if (rd_vld_r && !rd_bit_r) begin
        allset_r <= 1'b0;
      end
      if (out_valid_r && out_ready && (state_r != B_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_CLEAR: begin
          clr_r <= clr_r + IDX_W'(1);
          if (clr_r == {IDX_W{1'b1}}) begin
            state_r <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (job_valid) begin
            cmd_r    <= job_cmd;
            pos_r    <= job_pos;
            step_r   <= job_step;
            cnt_r    <= 5'd0;
            allset_r <= 1'b1;
            state_r  <= (hc_r == 5'd0) ? B_DONE : B_PROBE;
          end
        end
        B_PROBE: begin
          pos_r <= pos_r + step_r;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == hc_r - 5'd1) begin
            state_r <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          state_r <= B_DONE;
        end
        B_DONE: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_cmd_r     <= cmd_r;
            out_present_r <= (cmd_r == bfdh_pkg::CMD_QUERY) && allset_r;
            out_total_r   <= total_nxt;
            total_r       <= total_nxt;
            state_r       <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: verif/bfdh_result_checker.sv
// result checker for the bloom filter with double hashing: watches the config port and both
// channels, keeps its own bit array and hashes, and compares every result word in order
// depends on bfdh_pkg
`timescale 1ns / 100ps

module bfdh_result_checker #(
  parameter int FILTER_INDEX_BITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [4:0]  cfg_wr_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_key_byte,
  input  wire logic        in_last_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        out_done_command,
  input  wire logic        out_maybe_present,
  input  wire logic [31:0] out_entries_added,
  output int               fail_count,
  output int               pending_count
);

  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
  localparam int FILTER_SIZE = 1 << FILTER_INDEX_BITS;

  typedef struct packed {
    logic        command;
    logic        present;
    logic [31:0] total;
  } key_result_t;

  // bit array powers up cleared, reset is applied once
  bit          filter_mem [FILTER_SIZE];
  logic [63:0] fnv_state;
  logic [63:0] rot_state;
  logic [31:0] keys_inserted;
  logic [4:0]  probe_count;
  key_result_t result_q [$];

  function automatic logic [63:0] murmur_mix(input logic [63:0] v);
    logic [63:0] m;
    m = v ^ (v >> 33);
    m = m * bfdh_pkg::MIX_C1;
    m = m ^ (m >> 33);
    m = m * bfdh_pkg::MIX_C2;
    return m ^ (m >> 33);
  endfunction

  task automatic absorb_word(input logic cmd, input logic [7:0] b, input logic last);
    logic [63:0] mixed;
    logic [63:0] base;
    logic [63:0] stride;
    logic [63:0] probe;
    logic        all_set;
    key_result_t r;
    fnv_state = (fnv_state ^ {56'd0, b}) * FNV_PRIME;
    mixed = rot_state ^ ({56'd0, b} + bfdh_pkg::GOLDEN_ADD);
    rot_state = {mixed[50:0], mixed[63:51]} * FNV_PRIME;
    if (last) begin
      base = murmur_mix(fnv_state);
      stride = murmur_mix(rot_state);
      fnv_state = bfdh_pkg::SEED_PRI;
      rot_state = bfdh_pkg::SEED_SEC;
      probe = base;
      all_set = 1'b1;
      for (int i = 0; i < probe_count; i++) begin
        if (cmd == bfdh_pkg::CMD_INSERT) begin
          filter_mem[probe[FILTER_INDEX_BITS-1:0]] = 1'b1;
        end else if (!filter_mem[probe[FILTER_INDEX_BITS-1:0]]) begin
          all_set = 1'b0;
        end
        probe = probe + stride;
      end
      if (cmd == bfdh_pkg::CMD_INSERT && keys_inserted != 32'hffffffff) begin
        keys_inserted = keys_inserted + 1;
      end
      r.command = cmd;
      r.present = (cmd == bfdh_pkg::CMD_QUERY) && all_set;
      r.total = keys_inserted;
      result_q.insert(result_q.size(), r);
    end
  endtask

  always @(posedge clk) begin : watch
    key_result_t want;
    if (!rst_n) begin
      fnv_state = bfdh_pkg::SEED_PRI;
      rot_state = bfdh_pkg::SEED_SEC;
      keys_inserted = '0;
      probe_count = bfdh_pkg::HASH_COUNT_RST;
      result_q.delete();
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: result word with none expected: cmd %0d present %0d total %0d",
                   $time, out_done_command, out_maybe_present, out_entries_added);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (out_done_command !== want.command) begin
            $display("%0t: done_command expected %0d got %0d",
                     $time, want.command, out_done_command);
            fail_count++;
          end
          if (out_maybe_present !== want.present) begin
            $display("%0t: maybe_present expected %0d got %0d",
                     $time, want.present, out_maybe_present);
            fail_count++;
          end
          if (out_entries_added !== want.total) begin
            $display("%0t: entries_added expected %0d got %0d",
                     $time, want.total, out_entries_added);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready === 1'b1) begin
        absorb_word(in_command, in_key_byte, in_last_byte);
      end
      if (cfg_wr_en) begin
        probe_count = cfg_wr_data;
      end
    end
    pending_count = result_q.size();
  end

endmodule

// File: verif/tb_bloom_filter_double_hash.sv
// testbench top for the bloom filter with double hashing: drives keys byte by byte with
// bursty input and stalling output, steps hash_count through its range, gives the verdict
// depends on bfdh_pkg, bloom_filter_double_hash and bfdh_result_checker
`timescale 1ns / 100ps

module tb_bloom_filter_double_hash;

  localparam int FILTER_BITS = 20;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int PHASE_WORDS = 180;
  localparam int PHASES = 8;
  localparam int KEY_MAX = 20;
  localparam int STORE_DEPTH = 256;
  localparam int SETTLE_CYCLES = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = bfdh_pkg::CMD_INSERT;
  logic [7:0]  in_key_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_done_command;
  logic        out_maybe_present;
  logic [31:0] out_entries_added;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;

  logic [7:0]  key_buf [KEY_MAX];
  int          key_len = 0;
  logic [7:0]  saved_keys [STORE_DEPTH][KEY_MAX];
  int          saved_len [STORE_DEPTH];
  int          saved_total = 0;
  int          burst_left = 0;
  int          words_sent = 0;
  int          rx_mode = 0;
  int          rx_mode_left = 0;
  int          rx_hold = 0;

  bloom_filter_double_hash #(
    .FILTER_INDEX_BITS(FILTER_BITS)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_key_byte       (in_key_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_done_command  (out_done_command),
    .out_maybe_present (out_maybe_present),
    .out_entries_added (out_entries_added)
  );

  bfdh_result_checker #(
    .FILTER_INDEX_BITS(FILTER_BITS)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_key_byte       (in_key_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_done_command  (out_done_command),
    .out_maybe_present (out_maybe_present),
    .out_entries_added (out_entries_added),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_bloom_filter_double_hash: done, errors");
      $finish;
    end
  end

  // receiver: modes of steady, light, heavy and blocky stalling
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(64, 512);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 7);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold == 0) begin
          out_ready <= ~out_ready;
          rx_hold <= $urandom_range(1, 30);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  task automatic send_word(input logic cmd, input logic [7:0] b, input logic last);
    int pick;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      pick = $urandom_range(0, 9);
      burst_left = (pick == 0) ? 200 : (pick < 5) ? $urandom_range(1, 4) : $urandom_range(5, 20);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_key_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  // command on earlier bytes is random since only the last one counts
  task automatic send_key(input logic cmd);
    for (int i = 0; i < key_len; i++) begin
      if (i == key_len - 1) begin
        send_word(cmd, key_buf[i], 1'b1);
      end else begin
        send_word(1'($urandom_range(0, 1)), key_buf[i], 1'b0);
      end
    end
  endtask

  task automatic one_byte_key(input logic cmd, input logic [7:0] b);
    key_len = 1;
    key_buf[0] = b;
    send_key(cmd);
  endtask

  task automatic random_key();
    key_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, KEY_MAX) : $urandom_range(1, 6);
    for (int i = 0; i < key_len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        key_buf[i] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end else begin
        key_buf[i] = 8'($urandom_range(0, 255));
      end
    end
  endtask

  task automatic save_key();
    int slot;
    slot = saved_total % STORE_DEPTH;
    saved_len[slot] = key_len;
    for (int i = 0; i < key_len; i++) saved_keys[slot][i] = key_buf[i];
    saved_total++;
  endtask

  task automatic load_saved();
    int slot;
    slot = $urandom_range(0, ((saved_total < STORE_DEPTH) ? saved_total : STORE_DEPTH) - 1);
    key_len = saved_len[slot];
    for (int i = 0; i < key_len; i++) key_buf[i] = saved_keys[slot][i];
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_hash_count(input logic [4:0] value);
    in_valid <= 1'b0;
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    logic [4:0] fixed_counts [5];
    int         phase_start;
    int         pick;
    int         flip_at;
    fixed_counts = '{5'd0, 5'd31, 5'd12, 5'd1, 5'd16};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset hash_count: hit, miss, and command on early bytes ignored
    one_byte_key(bfdh_pkg::CMD_INSERT, 8'h00);
    one_byte_key(bfdh_pkg::CMD_QUERY, 8'hff);
    one_byte_key(bfdh_pkg::CMD_QUERY, 8'h00);
    send_word(bfdh_pkg::CMD_QUERY, 8'hff, 1'b0);
    send_word(bfdh_pkg::CMD_QUERY, 8'h00, 1'b0);
    send_word(bfdh_pkg::CMD_INSERT, 8'ha5, 1'b1);
    send_word(bfdh_pkg::CMD_INSERT, 8'hff, 1'b0);
    send_word(bfdh_pkg::CMD_INSERT, 8'h00, 1'b0);
    send_word(bfdh_pkg::CMD_QUERY, 8'ha5, 1'b1);
    // no probes at all
    set_hash_count(5'd0);
    one_byte_key(bfdh_pkg::CMD_INSERT, 8'h12);
    one_byte_key(bfdh_pkg::CMD_QUERY, 8'h34);
    // more probes than any insert so far
    set_hash_count(5'd31);
    one_byte_key(bfdh_pkg::CMD_QUERY, 8'h00);
    one_byte_key(bfdh_pkg::CMD_INSERT, 8'h77);
    one_byte_key(bfdh_pkg::CMD_QUERY, 8'h77);
    set_hash_count(5'd1);
    one_byte_key(bfdh_pkg::CMD_QUERY, 8'h80);
    set_hash_count(5'd16);
    key_len = 5;
    for (int i = 0; i < 5; i++) key_buf[i] = 8'hff;
    send_key(bfdh_pkg::CMD_INSERT);
    send_key(bfdh_pkg::CMD_QUERY);

    for (int p = 0; p < PHASES; p++) begin
      set_hash_count((p < 5) ? fixed_counts[p] : 5'($urandom_range(0, 31)));
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 40 || saved_total == 0) begin
          random_key();
          save_key();
          send_key(bfdh_pkg::CMD_INSERT);
        end else if (pick < 45) begin
          load_saved();
          send_key(bfdh_pkg::CMD_INSERT);
        end else if (pick < 72) begin
          load_saved();
          send_key(bfdh_pkg::CMD_QUERY);
        end else if (pick < 87) begin
          random_key();
          send_key(bfdh_pkg::CMD_QUERY);
        end else begin
          load_saved();
          flip_at = $urandom_range(0, key_len - 1);
          key_buf[flip_at] = key_buf[flip_at] ^ 8'(1 << $urandom_range(0, 7));
          send_key(bfdh_pkg::CMD_QUERY);
        end
      end
    end

    in_valid <= 1'b0;
    wait_idle();
    if (fail_count == 0) begin
      $display("tb_bloom_filter_double_hash: done, clean");
    end else begin
      $display("tb_bloom_filter_double_hash: done, errors");
    end
    $finish;
  end

endmodule
